// ===== sv/stereo_rotating_slot_treble_boost_unit_defines.svh =====
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef STEREO_ROTATING_SLOT_TREBLE_BOOST_UNIT_DEFINES_SVH
`define STEREO_ROTATING_SLOT_TREBLE_BOOST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SRSTB_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("srstb assertion failed");
`define SRSTB_ASSERT_NEVER(label, cond) \
	`SRSTB_ASSERT(label, !(cond))
`else
`define SRSTB_ASSERT(label, prop)
`define SRSTB_ASSERT_NEVER(label, cond)
`endif
`endif

// ===== sv/srstb_pkg.sv =====
package srstb_pkg;
	localparam int SAMPLE_BITS  = 24;
	localparam int GUARD_BITS   = 8;
	localparam int SLOT_BITS    = SAMPLE_BITS + GUARD_BITS;
	localparam int GAIN_BITS    = 18;
	localparam int NUM_SECTIONS = 8;
	localparam int NUM_SLOTS    = NUM_SECTIONS * (NUM_SECTIONS + 3) / 2;
	localparam int NUM_CHANNELS = 2;
	localparam int CFG_IDX_BITS = $clog2(NUM_SECTIONS);
	localparam int PHASE_BITS   = $clog2(NUM_SECTIONS + 2);
	localparam int ACC_BITS     = 48;
	localparam int ROUND_SHIFT  = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SLOT_BITS-1:0]   slot_t;
	typedef logic signed [GAIN_BITS-1:0]   gain_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic [PHASE_BITS-1:0]         phase_t;
	typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

	// first slot of section k, sections packed back to back
	function automatic int section_base(input int k);
		return k * (k + 3) / 2;
	endfunction

	function automatic slot_t sat_slot(input logic signed [SLOT_BITS+1:0] v);
		slot_t r;
		if (v > $signed({{2{1'b0}}, 1'b0, {(SLOT_BITS-1){1'b1}}})) begin
			r = {1'b0, {(SLOT_BITS-1){1'b1}}};
		end else if (v < $signed({{2{1'b1}}, 1'b1, {(SLOT_BITS-1){1'b0}}})) begin
			r = {1'b1, {(SLOT_BITS-1){1'b0}}};
		end else begin
			r = v[SLOT_BITS-1:0];
		end
		return r;
	endfunction

	function automatic sample_t sat_sample(input acc_t v);
		sample_t r;
		if (v > acc_t'($signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end else if (v < acc_t'($signed({1'b1, {(SAMPLE_BITS-1){1'b0}}}))) begin
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction
endpackage

// ===== sv/srstb_in_if.sv =====
interface srstb_in_if;
	import srstb_pkg::*;
	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;
	modport source(output valid, left_in, right_in, input ready);
	modport sink(input valid, left_in, right_in, output ready);
endinterface

// ===== sv/srstb_out_if.sv =====
interface srstb_out_if;
	import srstb_pkg::*;
	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;
	modport source(output valid, left_out, right_out, input ready);
	modport sink(input valid, left_out, right_out, output ready);
endinterface

// ===== sv/srstb_cfg_if.sv =====
interface srstb_cfg_if;
	import srstb_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	gain_t    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/stereo_rotating_slot_treble_boost_unit.sv =====
// Stereo treble boost: one stereo pair in, one boosted pair out, one pair per clock.
// Each pair is worked out in a single pass from the input port straight into the
// output register, so the output beat comes in the cycle after the accepted input
// beat, and a new pair is taken every cycle while the output register is free
// or being drained. The slot, history and phase state updates in the same edge. Gains
// are written through the config channel (index 0 = two-slot section .. 7 = nine-slot
// section), always ready, and should only change while no sample is in flight.
`include "stereo_rotating_slot_treble_boost_unit_defines.svh"
module stereo_rotating_slot_treble_boost_unit (
	input logic clk,
	input logic arst_n,
	srstb_in_if.sink in_ch,
	srstb_out_if.source out_ch,
	srstb_cfg_if.sink cfg
);
	import srstb_pkg::*;

	gain_t   gains_q [NUM_SECTIONS];
	phase_t  phase_q [NUM_SECTIONS];
	sample_t hist_q  [NUM_CHANNELS][NUM_SECTIONS];
	slot_t   slots_q [NUM_CHANNELS][NUM_SLOTS];
	slot_t   slots_nxt [NUM_CHANNELS][NUM_SLOTS];
	logic signed [SAMPLE_BITS+GAIN_BITS-1:0] prod_hi [NUM_CHANNELS][NUM_SECTIONS];
	logic signed [GUARD_BITS+GAIN_BITS:0]    prod_lo [NUM_CHANNELS][NUM_SECTIONS];
	sample_t x [NUM_CHANNELS];
	sample_t y [NUM_CHANNELS];
	sample_t y_q [NUM_CHANNELS];
	logic    out_valid_q;
	logic    accept;

	assign x[0] = in_ch.left_in;
	assign x[1] = in_ch.right_in;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SECTIONS; k++) gains_q[k] <= '0;
		end else if (cfg.valid) begin
			gains_q[cfg.index] <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SECTIONS; k++) phase_q[k] <= '0;
		end else if (accept) begin
			for (int k = 0; k < NUM_SECTIONS; k++) begin
				if (phase_q[k] == phase_t'(k + 1)) phase_q[k] <= '0;
				else phase_q[k] <= phase_q[k] + phase_t'(1);
			end
		end
	end

	for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_ch
		for (genvar k = 0; k < NUM_SECTIONS; k++) begin : g_sec
			localparam int N    = k + 2;
			localparam int BASE = section_base(k);
			phase_t p;
			phase_t q;
			logic signed [SLOT_BITS:0] dd;
			slot_t pre [N];
			slot_t cur;
			sample_t hi;

			assign p = phase_q[k];
			assign q = (p == '0) ? phase_t'(N - 1) : p - phase_t'(1);
			// difference scaled up to slot resolution
			assign dd = ($signed({hist_q[ch][k][SAMPLE_BITS-1], hist_q[ch][k]})
				- $signed({x[ch][SAMPLE_BITS-1], x[ch]})) <<< GUARD_BITS;

			for (genvar j = 0; j < N; j++) begin : g_slot
				always_comb begin
					if (p == phase_t'(j)) begin
						pre[j] = sat_slot((SLOT_BITS+2)'(slots_q[ch][BASE+j])
							+ (SLOT_BITS+2)'(dd));
					end else if (q == phase_t'(j)) begin
						pre[j] = sat_slot((SLOT_BITS+2)'(slots_q[ch][BASE+j])
							- (SLOT_BITS+2)'(dd));
					end else begin
						pre[j] = slots_q[ch][BASE+j];
					end
				end
			end

			always_comb begin
				cur = pre[0];
				for (int j = 1; j < N; j++) begin
					if (p == phase_t'(j)) cur = pre[j];
				end
			end

			assign hi = SAMPLE_BITS'(cur >>> GUARD_BITS);
			assign prod_hi[ch][k] = hi * gains_q[k];
			assign prod_lo[ch][k] = $signed({1'b0, cur[GUARD_BITS-1:0]}) * gains_q[k];

			if (k == 0) begin : g_leak
				// the two-slot pair leaks toward each other before halving
				logic signed [SLOT_BITS:0]   a_diff;
				logic signed [SLOT_BITS+1:0] a_sum;
				logic signed [SLOT_BITS:0]   b_diff;
				logic signed [SLOT_BITS+1:0] b_sum;
				slot_t a2;
				assign a_diff = (SLOT_BITS+1)'(pre[0]) - (SLOT_BITS+1)'(pre[1]);
				assign a_sum  = (SLOT_BITS+2)'(pre[0]) - (SLOT_BITS+2)'(a_diff >>> 8);
				assign a2     = SLOT_BITS'(a_sum >>> 1);
				assign b_diff = (SLOT_BITS+1)'(pre[1]) - (SLOT_BITS+1)'(a2);
				assign b_sum  = (SLOT_BITS+2)'(pre[1]) - (SLOT_BITS+2)'(b_diff >>> 8);
				assign slots_nxt[ch][BASE]   = a2;
				assign slots_nxt[ch][BASE+1] = SLOT_BITS'(b_sum >>> 1);
			end else begin : g_half
				for (genvar j = 0; j < N; j++) begin : g_h
					assign slots_nxt[ch][BASE+j] = pre[j] >>> 1;
				end
			end
		end

		acc_t sum_hi;
		acc_t sum_lo;
		acc_t corr;
		always_comb begin
			sum_hi = '0;
			sum_lo = '0;
			for (int k = 0; k < NUM_SECTIONS; k++) begin
				sum_hi = sum_hi + ACC_BITS'(prod_hi[ch][k]);
				sum_lo = sum_lo + ACC_BITS'(prod_lo[ch][k]);
			end
			corr = (sum_hi + (sum_lo >>> GUARD_BITS) + (acc_t'(1) <<< (ROUND_SHIFT - 1)))
				>>> ROUND_SHIFT;
		end
		assign y[ch] = sat_sample(ACC_BITS'(x[ch]) + corr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < NUM_SLOTS; i++) slots_q[ch][i] <= '0;
				for (int k = 0; k < NUM_SECTIONS; k++) hist_q[ch][k] <= '0;
			end else if (accept) begin
				for (int i = 0; i < NUM_SLOTS; i++) slots_q[ch][i] <= slots_nxt[ch][i];
				hist_q[ch][0] <= x[ch];
				for (int k = 1; k < NUM_SECTIONS; k++) hist_q[ch][k] <= hist_q[ch][k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (accept) y_q[ch] <= y[ch];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_out  = y_q[0];
	assign out_ch.right_out = y_q[1];

	`SRSTB_ASSERT(a_accept_gives_beat, (in_ch.valid && in_ch.ready) |=> out_ch.valid)
	`SRSTB_ASSERT_NEVER(a_no_take_when_stalled, out_ch.valid && !out_ch.ready && in_ch.ready)
	`SRSTB_ASSERT(a_beat_from_accept, $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready))
	`SRSTB_ASSERT_NEVER(a_two_slot_phase, phase_q[0] > phase_t'(1))
endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import srstb_pkg::*;

	localparam int LIMIT = 400000;

	typedef enum int {
		GAIN_TWO_SLOT, GAIN_THREE_SLOT, GAIN_FOUR_SLOT, GAIN_FIVE_SLOT,
		GAIN_SIX_SLOT, GAIN_SEVEN_SLOT, GAIN_EIGHT_SLOT, GAIN_NINE_SLOT
	} gain_reg_e;

	typedef struct {
		sample_t l;
		sample_t r;
	} pair_t;

	typedef struct {
		sample_t l;
		sample_t r;
		bit      typed;
		sample_t el;
		sample_t er;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	srstb_in_if  in_ch();
	srstb_out_if out_ch();
	srstb_cfg_if cfg();

	stereo_rotating_slot_treble_boost_unit uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	// boost model state
	longint gain_q16 [NUM_SECTIONS];
	longint history [2][NUM_SECTIONS];
	longint slots [2][NUM_SLOTS];
	int     phase [NUM_SECTIONS];

	pair_t  expected_pairs [$];
	int     errs = 0;
	int     cycles = 0;
	bit     quiet = 1'b0;
	bit     typed_on = 1'b0;
	pair_t  typed_pair;

	function automatic longint clip(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic longint boost_channel(input int c, input longint x);
		longint dd, cur, hi, sum_hi, sum_lo, corr, a, b;
		int base, n, p, q;
		sum_hi = 0;
		sum_lo = 0;
		for (int k = 0; k < NUM_SECTIONS; k++) begin
			n = k + 2;
			base = k * (k + 3) / 2;
			p = phase[k];
			q = (p == 0) ? n - 1 : p - 1;
			dd = (history[c][k] - x) * 256;
			slots[c][base+p] = clip(slots[c][base+p] + dd, SLOT_BITS);
			slots[c][base+q] = clip(slots[c][base+q] - dd, SLOT_BITS);
			cur = slots[c][base+p];
			hi = cur >>> GUARD_BITS;
			sum_hi += hi * gain_q16[k];
			sum_lo += (cur - hi * 256) * gain_q16[k];
			if (k == 0) begin
				// two-slot section leaks toward its partner
				a = slots[c][base];
				b = slots[c][base+1];
				a = (a - ((a - b) >>> 8)) >>> 1;
				b = (b - ((b - a) >>> 8)) >>> 1;
				slots[c][base] = a;
				slots[c][base+1] = b;
			end else begin
				for (int i = 0; i < n; i++)
					slots[c][base+i] = slots[c][base+i] >>> 1;
			end
		end
		corr = (sum_hi + (sum_lo >>> GUARD_BITS) + (longint'(1) <<< 15)) >>> 16;
		for (int i = NUM_SECTIONS - 1; i > 0; i--)
			history[c][i] = history[c][i-1];
		history[c][0] = x;
		return clip(x + corr, SAMPLE_BITS);
	endfunction

	function automatic pair_t boost_pair(input sample_t xl, input sample_t xr);
		pair_t y;
		y.l = sample_t'(boost_channel(0, longint'(xl)));
		y.r = sample_t'(boost_channel(1, longint'(xr)));
		for (int k = 0; k < NUM_SECTIONS; k++)
			phase[k] = (phase[k] + 1 >= k + 2) ? 0 : phase[k] + 1;
		return y;
	endfunction

	initial begin
		foreach (gain_q16[k]) begin
			gain_q16[k] = 0;
			phase[k] = 0;
			history[0][k] = 0;
			history[1][k] = 0;
		end
		foreach (slots[c, i]) slots[c][i] = 0;
	end

	always @(posedge clk) begin
		pair_t got, want, pred;
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pairs.size() == 0) begin
					$error("output beat with nothing expected");
					errs++;
				end else begin
					want = expected_pairs.pop_front();
					got.l = out_ch.left_out;
					got.r = out_ch.right_out;
					if (got.l !== want.l) begin
						$error("left_out expected %0d got %0d", want.l, got.l);
						errs++;
					end
					if (got.r !== want.r) begin
						$error("right_out expected %0d got %0d", want.r, got.r);
						errs++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				gain_q16[cfg.index] = longint'(cfg.data);
			if (in_ch.valid && in_ch.ready) begin
				pred = boost_pair(in_ch.left_in, in_ch.right_in);
				expected_pairs.push_back(typed_on ? typed_pair : pred);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	task automatic send_pair(input sample_t l, input sample_t r, input bit typed,
			input sample_t el, input sample_t er);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.left_in <= l;
		in_ch.right_in <= r;
		typed_on <= typed;
		typed_pair <= '{el, er};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_pairs.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_gains(input longint g [NUM_SECTIONS]);
		drain();
		for (int i = 0; i < NUM_SECTIONS; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= cfg_idx_t'(gain_reg_e'(i));
			cfg.data <= gain_t'(g[i]);
			@(posedge clk);
			while (!cfg.ready) @(posedge clk);
		end
		cfg.valid <= 1'b0;
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 5))
			0: return sample_t'($signed($urandom_range(0, 64)) - 32);
			1: return $urandom_range(0, 1) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
				: {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			default: return sample_t'($urandom);
		endcase
	endfunction

	localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	initial begin
		stim_row_t rows [$];
		longint g [NUM_SECTIONS];
		in_ch.valid = 1'b0;
		in_ch.left_in = '0;
		in_ch.right_in = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gains are zero after reset, so each beat passes straight through
		rows = '{
			'{24'sd0, 24'sd0, 1, 24'sd0, 24'sd0},
			'{SMAX, SMIN, 1, SMAX, SMIN},
			'{SMIN, SMAX, 1, SMIN, SMAX},
			'{-24'sd1, 24'sd1, 1, -24'sd1, 24'sd1},
			'{24'sh555555, 24'shAAAAAA, 1, 24'sh555555, 24'shAAAAAA},
			'{24'shAAAAAA, 24'sh555555, 1, 24'shAAAAAA, 24'sh555555},
			'{SMAX, SMAX, 1, SMAX, SMAX},
			'{SMIN, SMIN, 1, SMIN, SMIN}
		};
		foreach (rows[i]) send_pair(rows[i].l, rows[i].r, 1, rows[i].el, rows[i].er);

		// extreme gains, full swings drive slots and output into saturation
		for (int ph = 0; ph < 3; ph++) begin
			foreach (g[k])
				g[k] = (ph == 0) ? 65536 : (ph == 1) ? -65536 : ((k % 2) ? 131071 : -131072);
			load_gains(g);
			for (int i = 0; i < 12; i++)
				send_pair(i % 2 ? SMAX : SMIN, i % 3 ? SMIN : SMAX, 0, '0, '0);
			send_pair(24'sd0, 24'sd0, 0, '0, '0);
		end

		for (int ph = 0; ph < 5; ph++) begin
			foreach (g[k])
				g[k] = ($urandom_range(0, 4) == 0) ? longint'($signed(gain_t'($urandom)))
					: longint'($urandom_range(0, 131072)) - 65536;
			load_gains(g);
			if (ph == 4) quiet = 1'b1;
			for (int i = 0; i < 160; i++)
				send_pair(rand_sample(), rand_sample(), 0, '0, '0);
		end

		drain();
		if (errs == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
